// ===== hw/rtl/esc_pkg.sv =====
// esc_pkg: shared types, constants and shift helpers for the sensor
// compensation block. No dependencies.
package esc_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_CAL  = 3'd0,
    REG_PRESS_LO  = 3'd1,
    REG_PRESS_HI  = 3'd2,
    REG_MIXED_CAL = 3'd3,
    REG_HUM_CAL   = 3'd4
  } cfg_reg_t;

  localparam logic [63:0] K_T_OFFSET   = 64'd128000;
  localparam logic [63:0] K_P_BASE     = 64'd1048576;
  localparam logic [63:0] K_P_SCALE    = 64'd3125;
  localparam logic [63:0] K_P_BIAS47   = 64'h0000_8000_0000_0000;
  localparam logic [31:0] K_H_OFFSET   = 32'd76800;
  localparam logic [31:0] K_H_MAX      = 32'd419430400;
  localparam logic [31:0] K_H_ROUND    = 32'd16384;
  localparam logic [31:0] K_H_BIAS     = 32'd2097152;
  localparam logic [31:0] K_H_ROUND2   = 32'd8192;
  localparam logic [31:0] K_H_BIAS2    = 32'd32768;
  localparam logic [31:0] K_T_ROUND    = 32'd128;

  typedef struct packed {
    logic [19:0] t;
    logic [19:0] p;
    logic [15:0] h;
  } raw_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [47:0] mixed;
    logic [31:0] hum;
  } cal_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] n;
    logic [63:0] d;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
  } div_rsp_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [5:0] s);
    asr32 = $unsigned($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input logic [5:0] s);
    asr64 = $unsigned($signed(x) >>> s);
  endfunction

endpackage

// ===== hw/rtl/env_sensor_compensation.sv =====
// env_sensor_compensation: top level; calibration registers, input queue
// and compensation sequencer. Depends on esc_pkg, esc_front, esc_back.
//
//   channel  ports                          accepted when
//   input    in_push / in_full / in_raw_*   in_push && !in_full
//   result   out_pop / out_empty / out_*    out_pop && !out_empty
//   config   cfg_we / cfg_index / cfg_wdata cfg_we
//
// 21 products per item, 17 when the pressure divisor is zero, on the shared three-pass
// multiplier; the 64-step divider runs unless the pressure divisor is zero
// reset is synchronous; calibration registers clear to zero, both queues come up empty
// two raw items queue ahead of the sequencer and one result waits at the output
module env_sensor_compensation (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [19:0]                   in_raw_temperature,
  input  logic [19:0]                   in_raw_pressure,
  input  logic [15:0]                   in_raw_humidity,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [31:0]            out_temperature_centi,
  output logic [31:0]                   out_pressure_q24_8,
  output logic                          out_pressure_valid,
  output logic [16:0]                   out_humidity_q22_10,
  input  logic                          cfg_we,
  input  logic [esc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [esc_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import esc_pkg::*;

  cal_t        cal_r;
  raw_t        in_raw;
  raw_t        q_data;
  logic        q_valid, q_pop;
  logic [31:0] temp_u;

  assign in_raw = '{t: in_raw_temperature, p: in_raw_pressure, h: in_raw_humidity};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_CAL:  cal_r.temp     <= cfg_wdata[47:0];
        REG_PRESS_LO:  cal_r.press_lo <= cfg_wdata;
        REG_PRESS_HI:  cal_r.press_hi <= cfg_wdata;
        REG_MIXED_CAL: cal_r.mixed    <= cfg_wdata[47:0];
        REG_HUM_CAL:   cal_r.hum      <= cfg_wdata[31:0];
        default: begin end
      endcase
    end
  end

  esc_front u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .push_data(in_raw), .full(in_full),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  esc_back u_back (
    .clk(clk), .rst_n(rst_n), .cal(cal_r), .q_valid(q_valid), .q_data(q_data),
    .q_pop(q_pop), .out_empty(out_empty), .out_pop(out_pop),
    .out_temperature_centi(temp_u), .out_pressure_q24_8(out_pressure_q24_8),
    .out_pressure_valid(out_pressure_valid), .out_humidity_q22_10(out_humidity_q22_10)
  );

  assign out_temperature_centi = $signed(temp_u);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !in_full && out_empty)
    else $error("queues not empty after reset");

  a_press_forced: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pressure_valid |-> out_pressure_q24_8 == 32'd0)
    else $error("invalid pressure not zero");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_humidity_q22_10 <= 17'd102400)
    else $error("humidity above full scale");

endmodule

// ===== hw/rtl/esc_front.sv =====
// esc_front: two-entry input queue of raw readings.
// Depends on esc_pkg.
module esc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  esc_pkg::raw_t push_data,
  output logic          full,
  output logic          q_valid,
  output esc_pkg::raw_t q_data,
  input  logic          q_pop
);
  import esc_pkg::*;

  raw_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign full    = count_r == 2'd2;
  assign q_valid = count_r != 2'd0;
  assign q_data  = ent_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/esc_mul.sv =====
// esc_mul: shared 64x64 multiplier, low 64 bits, three passes of one
// 32x32 product. Depends on esc_pkg.
module esc_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  esc_pkg::mul_req_t req,
  output esc_pkg::mul_rsp_t rsp
);
  import esc_pkg::*;

  logic [63:0] a_r, b_r, acc_r;
  logic [1:0]  ph_r;
  logic        busy_r, done_r;
  logic [31:0] op_x, op_y;
  logic [63:0] prod;

  always_comb begin
    unique case (ph_r)
      2'd0:    begin op_x = a_r[31:0];  op_y = b_r[31:0];  end
      2'd1:    begin op_x = a_r[31:0];  op_y = b_r[63:32]; end
      default: begin op_x = a_r[63:32]; op_y = b_r[31:0];  end
    endcase
    prod = op_x * op_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        ph_r   <= 2'd0;
      end else if (busy_r) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end else if (busy_r) begin
      if (ph_r == 2'd0) begin
        acc_r <= prod;
      end else begin
        acc_r <= acc_r + {prod[31:0], 32'd0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

// ===== hw/rtl/esc_div.sv =====
// esc_div: 64-bit signed divider, truncating, one quotient bit a cycle.
// Depends on esc_pkg.
module esc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  esc_pkg::div_req_t req,
  output esc_pkg::div_rsp_t rsp
);
  import esc_pkg::*;

  logic [63:0] rem_r, nq_r, ad_r;
  logic        neg_r, busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [64:0] trial;
  logic        fits;

  assign trial = {rem_r, nq_r[63]};
  assign fits  = trial >= {1'b0, ad_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= 64'd0;
      nq_r  <= req.n[63] ? (64'd0 - req.n) : req.n;
      ad_r  <= req.d[63] ? (64'd0 - req.d) : req.d;
      neg_r <= req.n[63] ^ req.d[63];
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= trial[63:0] - ad_r;
        nq_r  <= {nq_r[62:0], 1'b1};
      end else begin
        rem_r <= trial[63:0];
        nq_r  <= {nq_r[62:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = neg_r ? (64'd0 - nq_r) : nq_r;

endmodule

// ===== hw/rtl/esc_back.sv =====
// esc_back: compensation sequencer and result register; drives the shared
// multiplier and divider. Depends on esc_pkg, esc_mul, esc_div.
module esc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  esc_pkg::cal_t cal,
  input  logic          q_valid,
  input  esc_pkg::raw_t q_data,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [31:0]   out_temperature_centi,
  output logic [31:0]   out_pressure_q24_8,
  output logic          out_pressure_valid,
  output logic [16:0]   out_humidity_q22_10
);
  import esc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_M10,
    S_DIV, S_M11, S_M12, S_M13, S_M14, S_M15, S_M16, S_M17, S_M18, S_M19,
    S_M20, S_M21, S_WR
  } state_t;

  state_t      state_r;
  logic        issued_r;
  raw_t        raw_r;
  logic [31:0] v1_r, tf_r, ha_r, hb_r, hc_r, hd_r, he_r, hv_r, hum_r;
  logic [63:0] x_r, sq_r, w2_r, w1_r, num_r, p_r;
  logic [31:0] press_r;
  logic        pvalid_r;
  logic        ovalid_r;
  logic [31:0] otemp_r, opress_r;
  logic        opvalid_r;
  logic [16:0] ohum_r;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] ta, tb, hv, temp_c, s15, hv_fin, mp32;
  logic [63:0] e1, pp, q13, mp, w1_nxt, x2, press_full;
  logic        mul_state;

  assign t1 = {16'd0, cal.temp[15:0]};
  assign t2 = {{16{cal.temp[31]}}, cal.temp[31:16]};
  assign t3 = {{16{cal.temp[47]}}, cal.temp[47:32]};
  assign p1 = {48'd0, cal.press_lo[15:0]};
  assign p2 = {{48{cal.press_lo[31]}}, cal.press_lo[31:16]};
  assign p3 = {{48{cal.press_lo[47]}}, cal.press_lo[47:32]};
  assign p4 = {{48{cal.press_lo[63]}}, cal.press_lo[63:48]};
  assign p5 = {{48{cal.press_hi[15]}}, cal.press_hi[15:0]};
  assign p6 = {{48{cal.press_hi[31]}}, cal.press_hi[31:16]};
  assign p7 = {{48{cal.press_hi[47]}}, cal.press_hi[47:32]};
  assign p8 = {{48{cal.press_hi[63]}}, cal.press_hi[63:48]};
  assign p9 = {{48{cal.mixed[15]}}, cal.mixed[15:0]};
  assign h1 = {24'd0, cal.mixed[23:16]};
  assign h2 = {{16{cal.mixed[39]}}, cal.mixed[39:24]};
  assign h3 = {24'd0, cal.mixed[47:40]};
  assign h4 = {{20{cal.hum[11]}}, cal.hum[11:0]};
  assign h5 = {{20{cal.hum[23]}}, cal.hum[23:12]};
  assign h6 = {{24{cal.hum[31]}}, cal.hum[31:24]};

  assign mp     = mrsp.p;
  assign mp32   = mrsp.p[31:0];
  assign ta     = {15'd0, raw_r.t[19:3]} - {15'd0, t1[15:0], 1'b0};
  assign tb     = {16'd0, raw_r.t[19:4]} - t1;
  assign e1     = {{32{tf_r[31]}}, tf_r} - K_T_OFFSET;
  assign pp     = K_P_BASE - {44'd0, raw_r.p};
  assign q13    = asr64(p_r, 6'd13);
  assign hv     = tf_r - K_H_OFFSET;
  assign s15    = asr32(hv_r, 6'd15);
  assign temp_c = asr32({tf_r[29:0], 2'b00} + tf_r + K_T_ROUND, 6'd8);
  assign w1_nxt = asr64(mp, 6'd33);
  assign x2     = asr64(mp, 6'd19);
  assign press_full = asr64(p_r + x_r + x2, 6'd8) + {p7[59:0], 4'd0};
  assign hv_fin = hv_r - asr32(mp32, 6'd4);

  assign mul_state = (state_r != S_IDLE) && (state_r != S_DIV) && (state_r != S_WR);

  always_comb begin
    mreq.start = mul_state && !issued_r;
    mreq.a     = 64'd0;
    mreq.b     = 64'd0;
    unique case (state_r)
      S_M1:  begin mreq.a = {32'd0, ta};   mreq.b = {32'd0, t2}; end
      S_M2:  begin mreq.a = {32'd0, tb};   mreq.b = {32'd0, tb}; end
      S_M3:  begin mreq.a = x_r;           mreq.b = {32'd0, t3}; end
      S_M4:  begin mreq.a = e1;            mreq.b = e1; end
      S_M5:  begin mreq.a = sq_r;          mreq.b = p6; end
      S_M6:  begin mreq.a = e1;            mreq.b = p5; end
      S_M7:  begin mreq.a = sq_r;          mreq.b = p3; end
      S_M8:  begin mreq.a = e1;            mreq.b = p2; end
      S_M9:  begin mreq.a = K_P_BIAS47 + x_r; mreq.b = p1; end
      S_M10: begin mreq.a = {pp[32:0], 31'd0} - w2_r; mreq.b = K_P_SCALE; end
      S_M11: begin mreq.a = p9;            mreq.b = q13; end
      S_M12: begin mreq.a = x_r;           mreq.b = q13; end
      S_M13: begin mreq.a = p8;            mreq.b = p_r; end
      S_M14: begin mreq.a = {32'd0, h5};   mreq.b = {32'd0, hv}; end
      S_M15: begin mreq.a = {32'd0, hv_r}; mreq.b = {32'd0, h6}; end
      S_M16: begin mreq.a = {32'd0, hv_r}; mreq.b = {32'd0, h3}; end
      S_M17: begin mreq.a = {32'd0, hb_r}; mreq.b = {32'd0, hc_r}; end
      S_M18: begin mreq.a = {32'd0, hd_r}; mreq.b = {32'd0, h2}; end
      S_M19: begin mreq.a = {32'd0, ha_r}; mreq.b = {32'd0, he_r}; end
      S_M20: begin mreq.a = {32'd0, s15};  mreq.b = {32'd0, s15}; end
      S_M21: begin mreq.a = x_r;           mreq.b = {32'd0, h1}; end
      default: begin end
    endcase
  end

  assign dreq.start = (state_r == S_DIV) && !issued_r;
  assign dreq.n     = num_r;
  assign dreq.d     = w1_r;
  assign q_pop      = (state_r == S_IDLE) && q_valid;

  esc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
  esc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (out_pop && ovalid_r && (state_r != S_WR)) begin
        ovalid_r <= 1'b0;
      end
      if (mreq.start || dreq.start) begin
        issued_r <= 1'b1;
      end
      if ((mul_state && mrsp.done) || (state_r == S_DIV && drsp.done)) begin
        issued_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            raw_r   <= q_data;
            state_r <= S_M1;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            p_r     <= drsp.q;
            state_r <= S_M11;
          end
        end
        S_WR: begin
          if (!ovalid_r || out_pop) begin
            ovalid_r  <= 1'b1;
            otemp_r   <= temp_c;
            opress_r  <= press_r;
            opvalid_r <= pvalid_r;
            ohum_r    <= hum_r[28:12];
            state_r   <= S_IDLE;
          end
        end
        default: begin
          if (mrsp.done) begin
            unique case (state_r)
              S_M1:  begin v1_r <= asr32(mp32, 6'd11); state_r <= S_M2; end
              S_M2:  begin x_r <= {32'd0, asr32(mp32, 6'd12)}; state_r <= S_M3; end
              S_M3:  begin tf_r <= v1_r + asr32(mp32, 6'd14); state_r <= S_M4; end
              S_M4:  begin sq_r <= mp; state_r <= S_M5; end
              S_M5:  begin w2_r <= mp; state_r <= S_M6; end
              S_M6:  begin
                w2_r    <= w2_r + {mp[46:0], 17'd0} + {p4[28:0], 35'd0};
                state_r <= S_M7;
              end
              S_M7:  begin x_r <= asr64(mp, 6'd8); state_r <= S_M8; end
              S_M8:  begin x_r <= x_r + {mp[51:0], 12'd0}; state_r <= S_M9; end
              S_M9:  begin
                w1_r <= w1_nxt;
                if (w1_nxt == 64'd0) begin
                  press_r  <= 32'd0;
                  pvalid_r <= 1'b0;
                  state_r  <= S_M14;
                end else begin
                  state_r <= S_M10;
                end
              end
              S_M10: begin num_r <= mp; state_r <= S_DIV; end
              S_M11: begin x_r <= mp; state_r <= S_M12; end
              S_M12: begin x_r <= asr64(mp, 6'd25); state_r <= S_M13; end
              S_M13: begin
                press_r  <= press_full[31:0];
                pvalid_r <= 1'b1;
                state_r  <= S_M14;
              end
              S_M14: begin
                hv_r    <= hv;
                ha_r    <= asr32({2'd0, raw_r.h, 14'd0} - {h4[11:0], 20'd0} - mp32
                                 + K_H_ROUND, 6'd15);
                state_r <= S_M15;
              end
              S_M15: begin hb_r <= asr32(mp32, 6'd10); state_r <= S_M16; end
              S_M16: begin hc_r <= asr32(mp32, 6'd11) + K_H_BIAS2; state_r <= S_M17; end
              S_M17: begin hd_r <= asr32(mp32, 6'd10) + K_H_BIAS; state_r <= S_M18; end
              S_M18: begin he_r <= asr32(mp32 + K_H_ROUND2, 6'd14); state_r <= S_M19; end
              S_M19: begin hv_r <= mp32; state_r <= S_M20; end
              S_M20: begin x_r <= {32'd0, asr32(mp32, 6'd7)}; state_r <= S_M21; end
              S_M21: begin
                if (hv_fin[31]) begin
                  hum_r <= 32'd0;
                end else if (hv_fin > K_H_MAX) begin
                  hum_r <= K_H_MAX;
                end else begin
                  hum_r <= hv_fin;
                end
                state_r <= S_WR;
              end
              default: begin end
            endcase
          end
        end
      endcase
    end
  end

  assign out_empty             = !ovalid_r;
  assign out_temperature_centi = otemp_r;
  assign out_pressure_q24_8    = opress_r;
  assign out_pressure_valid    = opvalid_r;
  assign out_humidity_q22_10   = ohum_r;

endmodule
